@@ src/rsum_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sum partition package
// Shared field widths, command codes and the structs passed between units.
// ----------------------------------------------------------------------------
package rsum_pkg;

   // Width of every payload field and configuration register.
   localparam int FIELD_W = 7;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PART = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PART = 1'b1;

   // Command classes produced by the front end.
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_FAIL   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TABLE  = 2'd3;

   // Command queue depth.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // One classified item, as handed from the front end to the back end.
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FIELD_W-1:0] target;
      logic [FIELD_W-1:0] lo;
      logic [FIELD_W-1:0] hi;
   } cmd_type;

   // Queue occupancy flags.
   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   // One result transfer.
   typedef struct packed {
      logic               valid;
      logic [FIELD_W-1:0] part;
      logic               last;
      logic               ok;
   } rsp_type;

endpackage

@@ src/rsum_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rsum_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 65
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/rsum_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sum partition front end
// Classifies an incoming target against the part limits into a command.
// ----------------------------------------------------------------------------
module rsum_front #(
   parameter int MAX_TARGET = 64
) (
   input  logic [rsum_pkg::FIELD_W-1:0] target,
   input  logic [rsum_pkg::FIELD_W-1:0] min_part,
   input  logic [rsum_pkg::FIELD_W-1:0] max_part,
   output rsum_pkg::cmd_type            cmd
);
   import rsum_pkg::*;

   logic [FIELD_W-1:0] lo;
   logic               fail;

   // A zero minimum behaves as a minimum of one.
   assign lo = (min_part == '0) ? FIELD_W'(1) : min_part;

   assign fail = (target == '0) || (target > FIELD_W'(MAX_TARGET)) ||
                 (target < lo) || (max_part < lo);

   // Order matters: a failure wins, then a single part, then the two split modes.
   always_comb begin
      cmd.target = target;
      cmd.lo     = lo;
      cmd.hi     = max_part;
      priority if (fail) begin
         cmd.kind = KIND_FAIL;
      end else if (target <= max_part) begin
         cmd.kind = KIND_SINGLE;
      end else if (lo == FIELD_W'(1)) begin
         cmd.kind = KIND_REPEAT;
      end else begin
         cmd.kind = KIND_TABLE;
      end
   end

endmodule

@@ src/rsum_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sum partition command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rsum_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rsum_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output rsum_pkg::cmd_type      head,
   output rsum_pkg::q_status_type status
);
   import rsum_pkg::*;

   cmd_type             entries_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ptr_ff;
   logic [Q_PTR_W-1:0]  wr_ptr_in;
   logic [Q_PTR_W-1:0]  rd_ptr_ff;
   logic [Q_PTR_W-1:0]  rd_ptr_in;
   logic [Q_CNT_W-1:0]  count_ff;
   logic [Q_CNT_W-1:0]  count_in;

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head         = entries_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == Q_CNT_W'(Q_DEPTH));

endmodule

@@ src/rsum_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sum partition back end
// Executes one command at a time: direct results, repeated maximum parts,
// or a coin-change table fill followed by a read back of the parts or a failure.
// ----------------------------------------------------------------------------
module rsum_back #(
   parameter int MAX_TARGET = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rsum_pkg::cmd_type      cmd,
   input  rsum_pkg::q_status_type q_status,
   output logic                   pop,
   output rsum_pkg::rsp_type      rsp
);
   import rsum_pkg::*;

   localparam int IDX_W = $clog2(MAX_TARGET + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_REP   = 3'd1;
   localparam logic [2:0] S_FILL  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_RD    = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]          state_ff;
   logic [2:0]          state_in;
   logic [MAX_TARGET:0] reach_ff;
   logic [MAX_TARGET:0] reach_in;
   logic [IDX_W-1:0]    idx_i_ff;
   logic [IDX_W-1:0]    idx_i_in;
   logic [IDX_W-1:0]    idx_j_ff;
   logic [IDX_W-1:0]    idx_j_in;
   logic [IDX_W-1:0]    tgt_ff;
   logic [IDX_W-1:0]    tgt_in;
   logic [IDX_W-1:0]    pos_ff;
   logic [IDX_W-1:0]    pos_in;
   logic [FIELD_W-1:0]  hi_ff;
   logic [FIELD_W-1:0]  hi_in;
   logic [FIELD_W-1:0]  rem_ff;
   logic [FIELD_W-1:0]  rem_in;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   logic [IDX_W-1:0]    diff;
   logic                hit;
   logic [FIELD_W-1:0]  rd_data;
   logic [IDX_W-1:0]    part_idx;
   logic [IDX_W-1:0]    pos_next;
   logic [FIELD_W-1:0]  rem_next;

   // Table fill: sum j is reachable with part i when sum j-i already is.
   assign diff = idx_j_ff - idx_i_ff;
   assign hit  = (state_ff == S_FILL) && reach_ff[diff];

   // Read back and repeat helpers.
   assign part_idx = rd_data[IDX_W-1:0];
   assign pos_next = pos_ff - part_idx;
   assign rem_next = rem_ff - hi_ff;

   assign pop = (state_ff == S_IDLE) && !q_status.empty;

   rsum_ram #(
      .WIDTH(FIELD_W),
      .DEPTH(MAX_TARGET + 1)
   ) u_table (
      .clock  (clock),
      .wr_en  (hit),
      .wr_addr(idx_j_ff),
      .wr_data(FIELD_W'(idx_i_ff)),
      .rd_addr(pos_ff),
      .rd_data(rd_data)
   );

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      reach_in   = reach_ff;
      idx_i_in   = idx_i_ff;
      idx_j_in   = idx_j_ff;
      tgt_in     = tgt_ff;
      pos_in     = pos_ff;
      hi_in      = hi_ff;
      rem_in     = rem_ff;
      rsp_in     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (pop) begin
               unique case (cmd.kind)
                  KIND_FAIL: begin
                     rsp_in.valid = 1'b1;
                     rsp_in.last  = 1'b1;
                  end
                  KIND_SINGLE: begin
                     rsp_in.valid = 1'b1;
                     rsp_in.part  = cmd.target;
                     rsp_in.last  = 1'b1;
                     rsp_in.ok    = 1'b1;
                  end
                  KIND_REPEAT: begin
                     rem_in   = cmd.target;
                     hi_in    = cmd.hi;
                     state_in = S_REP;
                  end
                  default: begin
                     // Table case: fresh reachability with only sum zero set.
                     reach_in    = '0;
                     reach_in[0] = 1'b1;
                     idx_i_in    = cmd.lo[IDX_W-1:0];
                     idx_j_in    = cmd.lo[IDX_W-1:0];
                     tgt_in      = cmd.target[IDX_W-1:0];
                     hi_in       = cmd.hi;
                     state_in    = S_FILL;
                  end
               endcase
            end
         end
         S_REP: begin
            // Emit the maximum while it fits, then the nonzero remainder.
            rsp_in.valid = 1'b1;
            rsp_in.ok    = 1'b1;
            if (rem_ff >= hi_ff) begin
               rsp_in.part = hi_ff;
               rem_in      = rem_next;
               if (rem_next == '0) begin
                  rsp_in.last = 1'b1;
                  state_in    = S_IDLE;
               end
            end else begin
               rsp_in.part = rem_ff;
               rsp_in.last = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_FILL: begin
            if (hit) begin
               reach_in[idx_j_ff] = 1'b1;
            end
            if (idx_j_ff == tgt_ff) begin
               if (FIELD_W'(idx_i_ff) == hi_ff) begin
                  state_in = S_CHECK;
               end else begin
                  idx_i_in = idx_i_ff + 1'b1;
                  idx_j_in = idx_i_ff + 1'b1;
               end
            end else begin
               idx_j_in = idx_j_ff + 1'b1;
            end
         end
         S_CHECK: begin
            if (!reach_ff[tgt_ff]) begin
               rsp_in.valid = 1'b1;
               rsp_in.last  = 1'b1;
               state_in     = S_IDLE;
            end else begin
               pos_in   = tgt_ff;
               state_in = S_RD;
            end
         end
         S_RD: begin
            // Table address is presented; data arrives next cycle.
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_in.valid = 1'b1;
            rsp_in.part  = rd_data;
            rsp_in.ok    = 1'b1;
            pos_in       = pos_next;
            if (pos_next == '0) begin
               rsp_in.last = 1'b1;
               state_in    = S_IDLE;
            end else begin
               state_in = S_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         reach_ff <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         reach_ff <= reach_in;
         rsp_ff   <= rsp_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      idx_i_ff    <= idx_i_in;
      idx_j_ff    <= idx_j_in;
      tgt_ff      <= tgt_in;
      pos_ff      <= pos_in;
      hi_ff       <= hi_in;
      rem_ff      <= rem_in;
   end

   assign rsp = rsp_ff;

endmodule

@@ src/range_sum_partition.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sum partition
// Splits a target into parts between min_part and max_part, one part per
// result transfer, the final one marked by rsp_last; failures clear rsp_ok.
// ----------------------------------------------------------------------------
// A target is transferred when start is high and busy is low; busy rises only
// when the two-entry command queue is full, and min_part and max_part are
// sampled at that transfer. Each result is presented for exactly one cycle on
// rsp_valid and cannot be held off. After the back end takes a command, a
// failure or a single part appears in the cycle after; repeated maximum parts
// come one per cycle. A table split makes one table update per cycle for each
// part size i = min..max and each sum from i to the target, checks the target,
// then reads back each part, presenting the table address in S_RD and taking
// the read data in S_OUT. The fill rate is set by the single update per cycle
// in the back end and the read back by the registered read port of the table.
module range_sum_partition #(
   parameter int MAX_TARGET = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [rsum_pkg::FIELD_W-1:0]   req_target,
   output logic                           rsp_valid,
   output logic [rsum_pkg::FIELD_W-1:0]   rsp_part,
   output logic                           rsp_last,
   output logic                           rsp_ok,
   input  logic                           csr_we,
   input  logic [rsum_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rsum_pkg::FIELD_W-1:0]   csr_wdata
);
   import rsum_pkg::*;

   logic [FIELD_W-1:0] min_part_ff;
   logic [FIELD_W-1:0] max_part_ff;
   cmd_type            front_cmd;
   cmd_type            head_cmd;
   q_status_type       q_status;
   logic               q_push;
   logic               q_pop;
   rsp_type            rsp;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_part_ff <= FIELD_W'(1);
         max_part_ff <= FIELD_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_PART: min_part_ff <= csr_wdata;
            CSR_MAX_PART: max_part_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input transfer pushes a classified command.
   assign busy   = q_status.full;
   assign q_push = start && !busy;

   rsum_front #(
      .MAX_TARGET(MAX_TARGET)
   ) u_front (
      .target  (req_target),
      .min_part(min_part_ff),
      .max_part(max_part_ff),
      .cmd     (front_cmd)
   );

   rsum_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_cmd(front_cmd),
      .pop     (q_pop),
      .head    (head_cmd),
      .status  (q_status)
   );

   rsum_back #(
      .MAX_TARGET(MAX_TARGET)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cmd     (head_cmd),
      .q_status(q_status),
      .pop     (q_pop),
      .rsp     (rsp)
   );

   assign rsp_valid = rsp.valid;
   assign rsp_part  = rsp.part;
   assign rsp_last  = rsp.last;
   assign rsp_ok    = rsp.ok;

`ifndef SYNTHESIS
   // A result that is not the last one means the back end is still busy.
   a_no_pop_mid_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !q_pop)
      else $error("command taken while an item still has results pending");

   // A failure result is a single marked transfer with a zero part.
   a_fail_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_last && (rsp_part == '0)))
      else $error("malformed failure result");

   // Successful parts are nonzero and never exceed the largest target.
   a_part_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ok) |->
         ((rsp_part != '0) && (rsp_part <= FIELD_W'(MAX_TARGET))))
      else $error("part out of range");

   // The back end never takes a command from an empty queue.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty command queue");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sum partition testbench
// Sends targets through the start/busy command port under several part size
// limits, predicts the split of every accepted target and checks each part
// transfer against the oldest predicted part, field by field.
// ----------------------------------------------------------------------------
module tb;
   import rsum_pkg::*;

   localparam int MAX_TARGET = 64;
   // Cycles allowed after the last part of a phase before the limits change.
   localparam int SETTLE_CYCLES = 8;
   // Bound on the wait for outstanding parts once every target is accepted.
   localparam int DRAIN_LIMIT = 20000;
   // Items per random phase and number of random phases.
   localparam int PHASE_ITEMS = 12;
   localparam int RANDOM_PHASES = 10;

   // One predicted part transfer.
   typedef struct packed {
      logic [FIELD_W-1:0] part;
      logic               last;
      logic               ok;
   } split_part_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [FIELD_W-1:0]   req_target = '0;
   logic                 rsp_valid;
   logic [FIELD_W-1:0]   rsp_part;
   logic                 rsp_last;
   logic                 rsp_ok;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MIN_PART;
   logic [FIELD_W-1:0]   csr_wdata = '0;

   // Targets still to be sent, and parts still to arrive.
   logic [FIELD_W-1:0] target_backlog[$];
   split_part_type     pending_parts[$];

   // Local copy of the part size limits.
   logic [FIELD_W-1:0] min_part_copy = 7'd1;
   logic [FIELD_W-1:0] max_part_copy = 7'd1;

   bit idle_enable = 1'b0;
   int gap_left = 0;
   int error_count = 0;

   range_sum_partition #(
      .MAX_TARGET(MAX_TARGET)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_target (req_target),
      .rsp_valid  (rsp_valid),
      .rsp_part   (rsp_part),
      .rsp_last   (rsp_last),
      .rsp_ok     (rsp_ok),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Works out the parts that one accepted target produces under the current
   // limits and queues them in order, the final one marked as last.
   task automatic predict_split(input logic [FIELD_W-1:0] target_value);
      int t;
      int lo;
      int hi;
      int n;
      int pos;
      int p;
      int split_parts[MAX_TARGET];
      bit reach[0:MAX_TARGET];
      int last_size[0:MAX_TARGET];
      split_part_type r;
      t = target_value;
      lo = (min_part_copy == 0) ? 1 : min_part_copy;
      hi = max_part_copy;
      n = 0;
      if (t == 0 || t > MAX_TARGET || t < lo || hi < lo) begin
         n = 0;
      end else if (t <= hi) begin
         split_parts[0] = t;
         n = 1;
      end else if (lo == 1) begin
         // Repeat the maximum, then whatever is left over.
         while (t >= hi) begin
            t -= hi;
            split_parts[n] = hi;
            n++;
         end
         if (t != 0) begin
            split_parts[n] = t;
            n++;
         end
      end else begin
         // Unbounded coin change: each sum remembers the largest size that
         // reaches it, then the parts are walked back from the target.
         for (int k = 0; k <= MAX_TARGET; k++) begin
            reach[k] = 1'b0;
            last_size[k] = 0;
         end
         reach[0] = 1'b1;
         for (int i = lo; i <= hi; i++) begin
            for (int j = i; j <= t; j++) begin
               if (reach[j - i]) begin
                  reach[j] = 1'b1;
                  last_size[j] = i;
               end
            end
         end
         if (reach[t]) begin
            pos = t;
            while (pos > 0 && n < MAX_TARGET) begin
               p = last_size[pos];
               if (p == 0 || p > pos) break;
               split_parts[n] = p;
               n++;
               pos -= p;
            end
         end
      end
      if (n == 0) begin
         r.part = '0;
         r.last = 1'b1;
         r.ok = 1'b0;
         pending_parts.insert(pending_parts.size(), r);
      end else begin
         for (int k = 0; k < n; k++) begin
            r.part = split_parts[k][FIELD_W-1:0];
            r.last = (k == n - 1);
            r.ok = 1'b1;
            pending_parts.insert(pending_parts.size(), r);
         end
      end
   endtask

   // Driver: a target transfers when start is high and busy is low.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_target <= '0;
      end else begin
         if (start && !busy) begin
            predict_split(req_target);
         end
         // While start is held against busy, the target stays on the port.
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (target_backlog.size() != 0) begin
               start <= 1'b1;
               req_target <= target_backlog.pop_front();
               if (idle_enable && $urandom_range(0, 3) == 0) begin
                  gap_left = $urandom_range(1, 16);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every part transfer is matched against the oldest prediction.
   always @(posedge clock) begin
      split_part_type want;
      if (!reset && rsp_valid) begin
         if (pending_parts.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("unexpected part transfer: part=%0d last=%0b ok=%0b",
                        rsp_part, rsp_last, rsp_ok);
            end
         end else begin
            want = pending_parts.pop_front();
            if (rsp_part !== want.part || rsp_last !== want.last
                || rsp_ok !== want.ok) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("part mismatch: expected part=%0d last=%0b ok=%0b, got part=%0d last=%0b ok=%0b",
                           want.part, want.last, want.ok, rsp_part, rsp_last, rsp_ok);
               end
            end
         end
      end
   end

   // Writes both limit registers back to back; only called while idle.
   task automatic set_limits(input logic [FIELD_W-1:0] lo, input logic [FIELD_W-1:0] hi);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_MIN_PART;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_MAX_PART;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we <= 1'b0;
      min_part_copy = lo;
      max_part_copy = hi;
   endtask

   // Waits until every target is sent and every predicted part has arrived.
   task automatic wait_quiet();
      int waited;
      waited = 0;
      @(posedge clock);
      while (target_backlog.size() != 0 || start) @(posedge clock);
      while (pending_parts.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_parts.size() != 0) begin
         error_count++;
         if (error_count <= 10) begin
            $display("%0d predicted parts never arrived", pending_parts.size());
         end
         pending_parts.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Picks limits for one random phase, mostly in the table region.
   task automatic random_limits();
      int lo;
      int hi;
      case ($urandom_range(0, 9))
         0: begin
            lo = $urandom_range(0, 1);
            hi = $urandom_range(1, 70);
         end
         1: begin
            lo = $urandom_range(5, 64);
            hi = $urandom_range(1, lo - 1);
         end
         2: begin
            lo = $urandom_range(2, 127);
            hi = $urandom_range(65, 127);
         end
         default: begin
            lo = $urandom_range(2, 12);
            hi = lo + $urandom_range(0, 12);
         end
      endcase
      set_limits(lo[FIELD_W-1:0], hi[FIELD_W-1:0]);
   endtask

   // Stimulus: directed corners first, then random phases.
   initial begin
      int t;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset limits of one: zero, one, the largest target, three and out of range.
      idle_enable = 1'b1;
      target_backlog.insert(target_backlog.size(), 7'd0);
      target_backlog.insert(target_backlog.size(), 7'd1);
      target_backlog.insert(target_backlog.size(), 7'd64);
      target_backlog.insert(target_backlog.size(), 7'd3);
      target_backlog.insert(target_backlog.size(), 7'd127);
      wait_quiet();

      // A zero minimum acts as one: repeated maximum with and without rest.
      set_limits(7'd0, 7'd7);
      target_backlog.insert(target_backlog.size(), 7'd20);
      target_backlog.insert(target_backlog.size(), 7'd21);
      target_backlog.insert(target_backlog.size(), 7'd7);
      target_backlog.insert(target_backlog.size(), 7'd65);
      wait_quiet();

      // Table split with unreachable targets and a target below the minimum.
      set_limits(7'd4, 7'd5);
      target_backlog.insert(target_backlog.size(), 7'd2);
      target_backlog.insert(target_backlog.size(), 7'd7);
      target_backlog.insert(target_backlog.size(), 7'd11);
      target_backlog.insert(target_backlog.size(), 7'd64);
      wait_quiet();

      // Maximum below the minimum: everything fails.
      set_limits(7'd9, 7'd4);
      target_backlog.insert(target_backlog.size(), 7'd9);
      target_backlog.insert(target_backlog.size(), 7'd64);
      wait_quiet();

      // Limits above the largest target, then only the maximum above it.
      set_limits(7'd127, 7'd127);
      target_backlog.insert(target_backlog.size(), 7'd64);
      wait_quiet();
      set_limits(7'd1, 7'd127);
      target_backlog.insert(target_backlog.size(), 7'd64);
      wait_quiet();

      // Single part at the top, the longest table fill, and a lone size.
      set_limits(7'd2, 7'd64);
      target_backlog.insert(target_backlog.size(), 7'd64);
      wait_quiet();
      set_limits(7'd2, 7'd63);
      target_backlog.insert(target_backlog.size(), 7'd64);
      target_backlog.insert(target_backlog.size(), 7'd63);
      wait_quiet();
      set_limits(7'd64, 7'd64);
      target_backlog.insert(target_backlog.size(), 7'd64);
      target_backlog.insert(target_backlog.size(), 7'd63);
      wait_quiet();

      // Random phases; the last ones run with the sender never idle.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         idle_enable = (ph < RANDOM_PHASES - 2);
         random_limits();
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            case ($urandom_range(0, 11))
               0: t = $urandom_range(65, 127);
               1: t = $urandom_range(0, 127);
               default: t = $urandom_range(1, MAX_TARGET);
            endcase
            target_backlog.insert(target_backlog.size(), t[FIELD_W-1:0]);
         end
         wait_quiet();
      end

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog, several times the slowest correct run.
   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
